@@ rtl/drp_pkg.sv @@
// Shared types, constants and codes for the downlink command replay filter.
`default_nettype none

package drp_pkg;

  // Stream and configuration widths.
  localparam int InDataW   = 64;
  localparam int OutDataW  = 120;
  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 2;

  // Default opcode values.
  localparam logic [7:0] OpPingCode  = 8'd1;
  localparam logic [7:0] OpRelayCode = 8'd2;
  localparam logic [7:0] OpExtraCode = 8'd3;

  // Frame shape limits.
  localparam logic [7:0] ShortLength = 8'd4;
  localparam logic [7:0] RelayLength = 8'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0] NodeIdReset  = 16'h0000;
  localparam logic [15:0] BcastIdReset = 16'hFFFF;
  localparam logic [7:0]  CmdPortReset = 8'd1;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_NODE_ID  = 2'd0,
    CFG_BCAST_ID = 2'd1,
    CFG_CMD_PORT = 2'd2
  } cfg_index_t;

  // Outcome of one frame.
  typedef enum logic [2:0] {
    RC_ACCEPTED     = 3'd0,
    RC_MALFORMED    = 3'd1,
    RC_WRONG_TARGET = 3'd2,
    RC_STALE        = 3'd3,
    RC_SAVE_FAILED  = 3'd4
  } reject_code_t;

  typedef struct packed {
    logic [15:0] node_id;
    logic [15:0] bcast_id;
    logic [7:0]  cmd_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_port;
    logic [7:0] frame_length;
    logic [7:0] target_high;
    logic [7:0] target_low;
    logic [7:0] opcode_byte;
    logic [7:0] sequence_byte;
    logic [7:0] argument_byte;
    logic       persist_ok;
  } frame_t;

  // Replay state as seen by the frame checks.
  typedef struct packed {
    logic       relay_on;
    logic [7:0] last_sequence;
    logic       sequence_valid;
  } state_t;

  // Decision taken for one frame.
  typedef struct packed {
    reject_code_t code;
    logic         strobe;
    logic         offer;
    logic         commit;
    logic         fail;
  } verdict_t;

endpackage

`default_nettype wire

@@ rtl/downlink_command_replay_filter.sv @@
// Top level of the downlink command replay filter.
// A frame is registered in the input register when accepted; its result is then
// registered in the result register once that register is free.
// Throughput: one frame per cycle while the result register drains; when a result
// stalls, the input register holds at most one more frame. Reset clears the valid
// flags, the replay state (relay on, no sequence known), the counters and
// restores the configuration defaults.
`default_nettype none

module downlink_command_replay_filter #(
  parameter logic [7:0] OP_PING_CODE  = drp_pkg::OpPingCode,
  parameter logic [7:0] OP_RELAY_CODE = drp_pkg::OpRelayCode,
  parameter logic [7:0] OP_EXTRA_CODE = drp_pkg::OpExtraCode
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [drp_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [drp_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // frame_port, frame_length, target_high, target_low, opcode_byte,
  // sequence_byte, argument_byte, persist_ok, zero pad
  input  wire logic [drp_pkg::InDataW-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // accepted, reject_code, relay_state, applied_sequence, sequence_known,
  // save_strobe, save_relay_value, rx_total, cmd_total, save_fail_total,
  // applied_opcode
  output logic [drp_pkg::OutDataW-1:0]       m_tdata
);
  import drp_pkg::*;

  cfg_t     cfg;
  frame_t   frame;
  state_t   state;
  verdict_t verdict;
  logic     frame_valid;
  logic     out_free;
  logic     fire;

  // Handshake: the input register moves on whenever the result register frees up.
  assign out_free = !m_tvalid || m_tready;
  assign fire     = frame_valid && out_free;
  assign s_tready = !frame_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_tready) begin
        frame_valid <= s_tvalid;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      frame.frame_port    <= s_tdata[7:0];
      frame.frame_length  <= s_tdata[15:8];
      frame.target_high   <= s_tdata[23:16];
      frame.target_low    <= s_tdata[31:24];
      frame.opcode_byte   <= s_tdata[39:32];
      frame.sequence_byte <= s_tdata[47:40];
      frame.argument_byte <= s_tdata[55:48];
      frame.persist_ok    <= s_tdata[56];
    end
  end

  drp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  drp_frame_check #(
    .OP_PING_CODE  (OP_PING_CODE),
    .OP_RELAY_CODE (OP_RELAY_CODE),
    .OP_EXTRA_CODE (OP_EXTRA_CODE)
  ) u_check (
    .frame   (frame),
    .cfg     (cfg),
    .state   (state),
    .verdict (verdict)
  );

  drp_state_update u_state (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .frame   (frame),
    .verdict (verdict),
    .state   (state),
    .result  (m_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/drp_cfg_regs.sv @@
// Configuration registers: node target, broadcast target and command port.
`default_nettype none

module drp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [drp_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [drp_pkg::CfgDataW-1:0]   cfg_data,
  output drp_pkg::cfg_t                       cfg
);
  import drp_pkg::*;

  // Writes to an index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id  <= NodeIdReset;
      cfg.bcast_id <= BcastIdReset;
      cfg.cmd_port <= CmdPortReset;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NODE_ID:  cfg.node_id  <= cfg_data;
        CFG_BCAST_ID: cfg.bcast_id <= cfg_data;
        CFG_CMD_PORT: cfg.cmd_port <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/drp_frame_check.sv @@
// Shape, target and replay window checks that classify one frame.
`default_nettype none

module drp_frame_check #(
  parameter logic [7:0] OP_PING_CODE  = drp_pkg::OpPingCode,
  parameter logic [7:0] OP_RELAY_CODE = drp_pkg::OpRelayCode,
  parameter logic [7:0] OP_EXTRA_CODE = drp_pkg::OpExtraCode
) (
  input  wire drp_pkg::frame_t frame,
  input  wire drp_pkg::cfg_t   cfg,
  input  wire drp_pkg::state_t state,
  output drp_pkg::verdict_t    verdict
);
  import drp_pkg::*;

  logic        shape_good;
  logic        malformed;
  logic [15:0] target;
  logic        wrong_target;
  logic [7:0]  delta;
  logic        stale;
  logic        next_relay;

  // Opcode-specific shape rules; the ping and extra rule wins on a tie.
  always_comb begin
    if (frame.opcode_byte == OP_PING_CODE || frame.opcode_byte == OP_EXTRA_CODE) begin
      shape_good = (frame.frame_length == ShortLength);
    end else if (frame.opcode_byte == OP_RELAY_CODE) begin
      shape_good = (frame.frame_length == RelayLength) && (frame.argument_byte[7:1] == 7'd0);
    end else begin
      shape_good = 1'b0;
    end
  end

  assign malformed = (frame.frame_port != cfg.cmd_port) ||
                     (frame.frame_length < ShortLength) || !shape_good;

  // Target is sent high byte first.
  assign target       = {frame.target_high, frame.target_low};
  assign wrong_target = (target != cfg.node_id) && (target != cfg.bcast_id);

  // Modulo-256 half-range window: delta must be 1..127 once a sequence is known.
  assign delta = frame.sequence_byte - state.last_sequence;
  assign stale = state.sequence_valid && ((delta == 8'd0) || delta[7]);

  assign next_relay = (frame.opcode_byte == OP_RELAY_CODE) ? (frame.argument_byte != 8'd0)
                                                           : state.relay_on;

  // Checks apply in order; only a frame that passes all of them attempts a save.
  always_comb begin
    verdict = '0;
    if (malformed) begin
      verdict.code = RC_MALFORMED;
    end else if (wrong_target) begin
      verdict.code = RC_WRONG_TARGET;
    end else if (stale) begin
      verdict.code = RC_STALE;
    end else begin
      verdict.strobe = 1'b1;
      verdict.offer  = next_relay;
      verdict.commit = frame.persist_ok;
      verdict.fail   = !frame.persist_ok;
      verdict.code   = frame.persist_ok ? RC_ACCEPTED : RC_SAVE_FAILED;
    end
  end

endmodule

`default_nettype wire

@@ rtl/drp_state_update.sv @@
// Replay state, wrapping counters and the registered result word.
`default_nettype none

module drp_state_update (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire drp_pkg::frame_t               frame,
  input  wire drp_pkg::verdict_t             verdict,
  output drp_pkg::state_t                    state,
  output logic [drp_pkg::OutDataW-1:0]       result
);
  import drp_pkg::*;

  logic        relay_on, relay_on_next;
  logic [7:0]  last_sequence, last_sequence_next;
  logic        sequence_valid, sequence_valid_next;
  logic [31:0] received_count, received_count_next;
  logic [31:0] command_count, command_count_next;
  logic [31:0] save_fail_count, save_fail_count_next;
  logic [7:0]  last_command, last_command_next;

  assign state.relay_on       = relay_on;
  assign state.last_sequence  = last_sequence;
  assign state.sequence_valid = sequence_valid;

  // Every frame counts; only a committed save changes the replay state.
  always_comb begin
    received_count_next  = received_count + 32'd1;
    save_fail_count_next = save_fail_count + {31'd0, verdict.fail};
    command_count_next   = command_count + {31'd0, verdict.commit};
    relay_on_next        = verdict.commit ? verdict.offer : relay_on;
    last_sequence_next   = verdict.commit ? frame.sequence_byte : last_sequence;
    sequence_valid_next  = verdict.commit | sequence_valid;
    last_command_next    = verdict.commit ? frame.opcode_byte : last_command;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_on        <= 1'b1;
      last_sequence   <= 8'd0;
      sequence_valid  <= 1'b0;
      received_count  <= 32'd0;
      command_count   <= 32'd0;
      save_fail_count <= 32'd0;
      last_command    <= 8'd0;
    end else if (fire) begin
      relay_on        <= relay_on_next;
      last_sequence   <= last_sequence_next;
      sequence_valid  <= sequence_valid_next;
      received_count  <= received_count_next;
      command_count   <= command_count_next;
      save_fail_count <= save_fail_count_next;
      last_command    <= last_command_next;
    end
  end

  // Result word shows the state after this frame.
  always_ff @(posedge clk) begin
    if (fire) begin
      result <= {last_command_next, save_fail_count_next, command_count_next,
                 received_count_next, verdict.offer, verdict.strobe,
                 sequence_valid_next, last_sequence_next, relay_on_next,
                 verdict.code, verdict.code == RC_ACCEPTED};
    end
  end

endmodule

`default_nettype wire

@@ rtl/drp_checker.sv @@
// Port-level checks on the replay filter result stream, bound to the top level.
`default_nettype none

module drp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [drp_pkg::OutDataW-1:0]  m_tdata
);
  import drp_pkg::*;

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The accepted flag agrees with the reject code.
  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0] == (m_tdata[3:1] == RC_ACCEPTED))
    else $error("accepted flag disagrees with reject code");

  // An accepted frame attempted a save and leaves a known sequence.
  a_accept_save: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[14] && m_tdata[13])
    else $error("accepted frame without save or known sequence");

  // A failed save was attempted.
  a_fail_strobe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:1] == RC_SAVE_FAILED |-> m_tdata[14])
    else $error("save failure reported without a save attempt");

  // No relay value is offered without a save attempt.
  a_offer_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[14] |-> !m_tdata[15])
    else $error("relay value offered without a save attempt");

endmodule

bind downlink_command_replay_filter drp_checker u_drp_checker (.*);

`default_nettype wire

@@ tb/downlink_command_replay_filter_tb.sv @@
// Self-checking testbench for the downlink command replay filter.
module downlink_command_replay_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drp_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CfgIndexW-1:0] CfgUnusedIndex = 2'd3;
  localparam int unsigned QuietLimit = 1000;

  // Fields of one result request, lowest bits last.
  typedef struct packed {
    logic [7:0]   applied_opcode;
    logic [31:0]  save_fail_total;
    logic [31:0]  cmd_total;
    logic [31:0]  rx_total;
    logic         save_relay_value;
    logic         save_strobe;
    logic         sequence_known;
    logic [7:0]   applied_sequence;
    logic         relay_state;
    reject_code_t reject_code;
    logic         accepted;
  } frame_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // frame_port, frame_length, target_high, target_low, opcode_byte,
  // sequence_byte, argument_byte, persist_ok, zero pad
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // accepted, reject_code, relay_state, applied_sequence, sequence_known,
  // save_strobe, save_relay_value, rx_total, cmd_total, save_fail_total,
  // applied_opcode
  logic [OutDataW-1:0] m_tdata;

  // Predicted configuration and replay state.
  logic [15:0] node_id = NodeIdReset;
  logic [15:0] bcast_id = BcastIdReset;
  logic [7:0] cmd_port = CmdPortReset;
  logic relay_flag = 1'b1;
  logic [7:0] seq_last = '0;
  logic seq_known = 1'b0;
  logic [31:0] frames_seen = '0;
  logic [31:0] commands_done = '0;
  logic [31:0] saves_failed = '0;
  logic [7:0] opcode_last = '0;

  frame_status_t expected_status[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_stall = 0;
  logic idling_on = 1'b1;

  downlink_command_replay_filter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Applies one frame to the predicted state and returns the status it should produce.
  function automatic frame_status_t predict_frame(frame_t f);
    frame_status_t s;
    reject_code_t code;
    logic shape_ok;
    logic next_relay;
    logic [7:0] delta;
    logic strobe;
    logic offer;
    frames_seen = frames_seen + 32'd1;
    strobe = 1'b0;
    offer = 1'b0;
    delta = f.sequence_byte - seq_last;
    if (f.opcode_byte == OpPingCode || f.opcode_byte == OpExtraCode) begin
      shape_ok = (f.frame_length == ShortLength);
    end else if (f.opcode_byte == OpRelayCode) begin
      shape_ok = (f.frame_length == RelayLength) && (f.argument_byte <= 8'd1);
    end else begin
      shape_ok = 1'b0;
    end
    if (f.frame_port != cmd_port || !shape_ok) begin
      code = RC_MALFORMED;
    end else if ({f.target_high, f.target_low} != node_id &&
                 {f.target_high, f.target_low} != bcast_id) begin
      code = RC_WRONG_TARGET;
    end else if (seq_known && (delta == 8'd0 || delta > 8'd127)) begin
      code = RC_STALE;
    end else begin
      next_relay = (f.opcode_byte == OpRelayCode) ? (f.argument_byte != 8'd0) : relay_flag;
      strobe = 1'b1;
      offer = next_relay;
      if (!f.persist_ok) begin
        saves_failed = saves_failed + 32'd1;
        code = RC_SAVE_FAILED;
      end else begin
        code = RC_ACCEPTED;
        seq_known = 1'b1;
        seq_last = f.sequence_byte;
        opcode_last = f.opcode_byte;
        commands_done = commands_done + 32'd1;
        relay_flag = next_relay;
      end
    end
    s.accepted = (code == RC_ACCEPTED);
    s.reject_code = code;
    s.relay_state = relay_flag;
    s.applied_sequence = seq_last;
    s.sequence_known = seq_known;
    s.save_strobe = strobe;
    s.save_relay_value = offer;
    s.rx_total = frames_seen;
    s.cmd_total = commands_done;
    s.save_fail_total = saves_failed;
    s.applied_opcode = opcode_last;
    return s;
  endfunction

  function automatic frame_t make_frame(logic [7:0] port, logic [7:0] len, logic [15:0] target,
                                        logic [7:0] op, logic [7:0] seq, logic [7:0] arg,
                                        logic ok);
    frame_t f;
    f.frame_port = port;
    f.frame_length = len;
    f.target_high = target[15:8];
    f.target_low = target[7:0];
    f.opcode_byte = op;
    f.sequence_byte = seq;
    f.argument_byte = arg;
    f.persist_ok = ok;
    return f;
  endfunction

  // Mostly well-formed commands inside the replay window, plus near misses and noise.
  function automatic frame_t random_frame();
    frame_t f;
    int unsigned pick;
    int unsigned sel;
    f.frame_port = 8'($urandom);
    f.frame_length = 8'($urandom);
    f.target_high = 8'($urandom);
    f.target_low = 8'($urandom);
    f.opcode_byte = 8'($urandom);
    f.sequence_byte = 8'($urandom);
    f.argument_byte = 8'($urandom);
    f.persist_ok = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      f.frame_port = cmd_port;
      case ($urandom_range(0, 2))
        0: f.opcode_byte = OpPingCode;
        1: f.opcode_byte = OpRelayCode;
        default: f.opcode_byte = OpExtraCode;
      endcase
      if (f.opcode_byte == OpRelayCode) begin
        f.frame_length = RelayLength;
        f.argument_byte = 8'($urandom_range(0, 1));
      end else begin
        f.frame_length = ShortLength;
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        {f.target_high, f.target_low} = node_id;
      end else if (sel < 9) begin
        {f.target_high, f.target_low} = bcast_id;
      end
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        f.sequence_byte = seq_last + 8'($urandom_range(1, 127));
      end else if (sel == 8) begin
        f.sequence_byte = seq_last;
      end else begin
        f.sequence_byte = seq_last + 8'($urandom_range(128, 255));
      end
      // A few otherwise good commands get a broken shape.
      if (pick >= 74) begin
        f.frame_length = 8'($urandom_range(0, 8));
        if ($urandom_range(0, 1) == 0) f.argument_byte = 8'($urandom_range(0, 3));
      end
    end else if (pick < 90) begin
      f.frame_port = cmd_port;
      f.frame_length = 8'($urandom_range(0, 8));
      f.opcode_byte = 8'($urandom_range(0, 4));
    end
    return f;
  endfunction

  // Sends one frame request, with an optional gap first, and records its prediction.
  task automatic send_frame(frame_t f);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, f.persist_ok, f.argument_byte, f.sequence_byte, f.opcode_byte,
                f.target_low, f.target_high, f.frame_length, f.frame_port};
    do @(posedge clk); while (!s_tready);
    expected_status.push_back(predict_frame(f));
  endtask

  // Stops sending and waits until every result is in and the pipeline is empty.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_NODE_ID: node_id = value;
      CFG_BCAST_ID: bcast_id = value;
      CFG_CMD_PORT: cmd_port = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_frame(random_frame());
  endtask

  // Each command opcode, every shape rule, both targets and the edges of the replay window.
  task automatic test_directed();
    send_frame(make_frame(8'd0, 8'd0, 16'h0000, 8'd0, 8'd0, 8'd0, 1'b0));
    send_frame(make_frame(8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1));
    send_frame(make_frame(8'd1, 8'd3, 16'h0000, OpPingCode, 8'h10, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd5, 16'h0000, OpPingCode, 8'h10, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, OpRelayCode, 8'h10, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd5, 16'h0000, OpRelayCode, 8'h10, 8'd2, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, 8'd0, 8'h10, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, 8'd255, 8'h10, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h1234, OpPingCode, 8'h10, 8'd0, 1'b1));
    // Save fails while no sequence is known yet.
    send_frame(make_frame(8'd1, 8'd4, 16'hFFFF, OpPingCode, 8'h80, 8'd0, 1'b0));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, OpPingCode, 8'h80, 8'd0, 1'b1));
    // Duplicate, half-range and just-behind sequences are stale.
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, OpPingCode, 8'h80, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, OpPingCode, 8'h00, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, OpPingCode, 8'h7F, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'hFFFF, OpPingCode, 8'hFF, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd5, 16'h0000, OpRelayCode, 8'h00, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd5, 16'h0000, OpRelayCode, 8'h01, 8'd1, 1'b0));
    send_frame(make_frame(8'd1, 8'd4, 16'h0000, OpExtraCode, 8'h02, 8'hFF, 1'b1));
    send_frame(make_frame(8'd1, 8'd5, 16'hFFFF, OpRelayCode, 8'h03, 8'd1, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'hFFFF, OpExtraCode, 8'h82, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'h00FF, OpPingCode, 8'h83, 8'd0, 1'b1));
    send_frame(make_frame(8'd1, 8'd4, 16'hFF00, OpPingCode, 8'h83, 8'd0, 1'b1));
    wait_drained();
  endtask

  // Random traffic under several register settings, the extremes among them.
  task automatic test_register_settings();
    logic [15:0] node_set[5];
    logic [15:0] bcast_set[5];
    logic [7:0] port_set[5];
    node_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hA5C3, 16'($urandom)};
    bcast_set = '{16'hFFFF, 16'h0000, 16'h0000, 16'h5A3C, 16'($urandom)};
    port_set = '{8'd1, 8'd255, 8'd0, 8'h80, 8'($urandom)};
    for (int i = 0; i < 5; i++) begin
      write_reg(CFG_NODE_ID, node_set[i]);
      write_reg(CFG_BCAST_ID, bcast_set[i]);
      write_reg(CFG_CMD_PORT, {8'($urandom), port_set[i]});
      write_reg(CfgUnusedIndex, 16'($urandom));
      send_random(220);
      wait_drained();
    end
  endtask

  // The sender holds off after each frame until its result has come back.
  task automatic test_drain_pause();
    repeat (50) begin
      send_frame(random_frame());
      wait_drained();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_quiet_finish();
    idling_on = 1'b0;
    send_random(380);
    wait_drained();
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Checks each result request against the oldest prediction.
  always @(posedge clk) begin
    frame_status_t got;
    frame_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = frame_status_t'(m_tdata);
      if (expected_status.size() == 0) begin
        $error("result arrived with no frame pending");
        error_count++;
      end else begin
        want = expected_status.pop_front();
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("reject_code", want.reject_code, got.reject_code);
        compare_field("relay_state", want.relay_state, got.relay_state);
        compare_field("applied_sequence", want.applied_sequence, got.applied_sequence);
        compare_field("sequence_known", want.sequence_known, got.sequence_known);
        compare_field("save_strobe", want.save_strobe, got.save_strobe);
        compare_field("save_relay_value", want.save_relay_value, got.save_relay_value);
        compare_field("rx_total", want.rx_total, got.rx_total);
        compare_field("cmd_total", want.cmd_total, got.cmd_total);
        compare_field("save_fail_total", want.save_fail_total, got.save_fail_total);
        compare_field("applied_opcode", want.applied_opcode, got.applied_opcode);
      end
    end
  end

  // Receiver stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (idling_on && sink_stall != 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Ends the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_settings();
    test_drain_pause();
    test_quiet_finish();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
